[rtl/core/ucwh_pkg.sv]
package ucwh_pkg;

  // Commitment memory geometry. NUM_FRAMES is a power of two so that the
  // frame number wraps by simply dropping its upper bits.
  localparam int unsigned NUM_FRAMES = 64;
  localparam int unsigned FRAME_W    = $clog2(NUM_FRAMES);
  localparam int unsigned AGE_BITS   = 16;
  localparam int unsigned AGE_EXT    = (AGE_BITS > 16) ? AGE_BITS : 16;

  // Field widths.
  localparam int unsigned FRAME_ID_W = 6;
  localparam int unsigned TARGET_W   = 16;
  localparam int unsigned SCORE_IN_W = 18;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned PC_W       = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // A score of 1.0 in Q1.15.
  localparam logic [SCORE_W-1:0] SCORE_ONE = 16'h8000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIE_BREAK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COMMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 2'd2;

  // Tie break modes.
  localparam logic [1:0] TIE_FIRST = 2'd0;
  localparam logic [1:0] TIE_LAST  = 2'd1;
  localparam logic [1:0] TIE_KEEP  = 2'd2;

  // Clamp a signed Q2.15 score to the range 0 to 1.0.
  function automatic logic [SCORE_W-1:0] clamp_score(input logic [SCORE_IN_W-1:0] raw);
    logic [SCORE_W-1:0] res;
    if (raw[SCORE_IN_W-1]) begin
      res = '0;
    end else if (raw > {{(SCORE_IN_W-SCORE_W){1'b0}}, SCORE_ONE}) begin
      res = SCORE_ONE;
    end else begin
      res = raw[SCORE_W-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/utility_choice_with_hysteresis_core.sv]
// Utility choice with hysteresis. Candidates of one decision arrive as a run
// of requests, one per cycle, the final one flagged by last_i; one result is
// issued per decision. A new request can be taken every cycle. The input only
// stalls while a finished decision waits behind a result that is itself held
// by out_stall_i. A decision's result enters the output register as its
// last request leaves the decision stage. Each request reads the commitment
// entry of its own frame from a synchronous memory with one read and one write
// port at acceptance. The decision stage writes the updated entry back as it
// issues a result, and a forwarding register covers a read that coincides
// with that write. Valid bits for the 64 entries are cleared at reset, so no
// clearing pass is needed. Configuration is written through a port that is
// always ready, and must only be written while the block is idle.
module utility_choice_with_hysteresis_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ucwh_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ucwh_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Candidate requests.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ucwh_pkg::FRAME_ID_W-1:0]      frame_id_i,
  input  logic [ucwh_pkg::TARGET_W-1:0]        target_i,
  input  logic signed [ucwh_pkg::SCORE_IN_W-1:0] score_i,
  input  logic [ucwh_pkg::PC_W-1:0]            resume_pc_i,
  input  logic                                 last_i,
  // Decision results.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ucwh_pkg::TARGET_W-1:0]        chosen_target_o,
  output logic [ucwh_pkg::PC_W-1:0]            resume_pc_out_o,
  output logic                                 tie_break_used_o,
  output logic                                 min_commit_blocked_o,
  output logic                                 hysteresis_blocked_o,
  output logic                                 had_commit_before_o,
  output logic [ucwh_pkg::TARGET_W-1:0]        commit_before_o,
  output logic [15:0]                          age_before_o
);
  import ucwh_pkg::*;

  localparam int unsigned MEM_W = TARGET_W + AGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // Configuration registers.
  logic [1:0]            tie_mode_q;
  logic [15:0]           min_commit_q;
  logic [15:0]           margin_q;

  // Commitment memory and its valid bits.
  logic [MEM_W-1:0]      mem_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] has_q;

  // Decision stage registers.
  logic                  s1_valid_q, s1_valid_d;
  logic [FRAME_W-1:0]    s1_frame_q;
  logic [TARGET_W-1:0]   s1_tgt_q;
  logic [SCORE_IN_W-1:0] s1_score_q;
  logic [PC_W-1:0]       s1_pc_q;
  logic                  s1_last_q;
  logic [MEM_W-1:0]      rd_data_q;
  logic                  rd_has_q;

  // Forwarding register holding the most recent write.
  logic                  fwd_valid_q;
  logic [FRAME_W-1:0]    fwd_addr_q;
  logic [MEM_W-1:0]      fwd_data_q;

  // Running registers of the current decision.
  logic [SCORE_W-1:0]    best_q, best_d;
  logic [TARGET_W-1:0]   first_q, first_d;
  logic [TARGET_W-1:0]   lastb_q, lastb_d;
  logic                  tied_q, tied_d;
  logic                  cib_q, cib_d;
  logic                  cseen_q, cseen_d;
  logic [SCORE_W-1:0]    cscore_q, cscore_d;
  logic                  started_q;

  // Output register.
  logic                  out_valid_q;

  logic                  in_acc, s1_adv, s1_fire;
  logic [FRAME_W-1:0]    in_frame;
  logic                  fwd_hit;
  logic                  has_c;
  logic [TARGET_W-1:0]   ctgt_c;
  logic [AGE_BITS-1:0]   age_c;
  logic [SCORE_W-1:0]    sc;
  logic                  is_comm;
  logic [TARGET_W-1:0]   winner;
  logic                  min_blk, hys_blk;
  logic [AGE_BITS-1:0]   age_new;
  logic [AGE_EXT-1:0]    age_ext;
  logic [16:0]           hys_limit;

  // Handshakes: the decision stage moves on unless a finished result is blocked.
  assign cfg_ready_o = 1'b1;
  assign s1_adv      = !s1_last_q || !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign s1_fire     = s1_valid_q && s1_adv && s1_last_q;
  assign in_frame    = frame_id_i[FRAME_W-1:0];

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // Commitment entry of the current request, with forwarding of a same-edge write.
  assign fwd_hit = fwd_valid_q && (fwd_addr_q == s1_frame_q);
  assign has_c   = fwd_hit ? 1'b1 : rd_has_q;
  assign ctgt_c  = fwd_hit ? fwd_data_q[MEM_W-1:AGE_BITS] : rd_data_q[MEM_W-1:AGE_BITS];
  assign age_c   = fwd_hit ? fwd_data_q[AGE_BITS-1:0] : rd_data_q[AGE_BITS-1:0];

  // Running best and tie tracking for this candidate.
  assign sc      = clamp_score(s1_score_q);
  assign is_comm = has_c && (s1_tgt_q == ctgt_c);

  always_comb begin
    best_d   = best_q;
    first_d  = first_q;
    lastb_d  = lastb_q;
    tied_d   = tied_q;
    cib_d    = cib_q;
    if (!started_q || sc > best_q) begin
      best_d  = sc;
      first_d = s1_tgt_q;
      lastb_d = s1_tgt_q;
      tied_d  = 1'b0;
      cib_d   = is_comm;
    end else if (sc == best_q) begin
      lastb_d = s1_tgt_q;
      tied_d  = 1'b1;
      cib_d   = cib_q || is_comm;
    end
    cseen_d  = cseen_q || is_comm;
    cscore_d = (is_comm && !cseen_q) ? sc : cscore_q;
  end

  // Final decision: tie break, then the minimum age and hysteresis guards.
  assign hys_limit = {1'b0, cscore_d} + {1'b0, margin_q};
  assign age_ext   = AGE_EXT'(age_c);

  always_comb begin
    winner  = first_d;
    min_blk = 1'b0;
    hys_blk = 1'b0;
    if (tied_d) begin
      case (tie_mode_q)
        TIE_LAST: begin
          winner = lastb_d;
        end
        TIE_KEEP: begin
          if (has_c && cib_d) begin
            winner = ctgt_c;
          end
        end
        default: begin
          winner = first_d;
        end
      endcase
    end
    if (has_c && cseen_d && (winner != ctgt_c)) begin
      if ((min_commit_q != '0) && (age_ext < AGE_EXT'(min_commit_q))) begin
        winner  = ctgt_c;
        min_blk = 1'b1;
      end else if ({1'b0, best_d} < hys_limit) begin
        winner  = ctgt_c;
        hys_blk = 1'b1;
      end
    end
  end

  // Staying ages the commitment, switching restarts it.
  always_comb begin
    if (has_c && (winner == ctgt_c)) begin
      age_new = (age_c == AGE_MAX) ? age_c : age_c + AGE_BITS'(1);
    end else begin
      age_new = '0;
    end
  end

  // Commitment memory: read at acceptance, write back at the decision.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mem_q[s1_frame_q] <= {winner, age_new};
    end
    if (in_acc) begin
      rd_data_q <= mem_q[in_frame];
    end
  end

  // Request payload of the decision stage and the forwarded write data.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_frame_q <= in_frame;
      s1_tgt_q   <= target_i;
      s1_score_q <= score_i;
      s1_pc_q    <= resume_pc_i;
      s1_last_q  <= last_i;
    end
    if (s1_fire) begin
      fwd_addr_q <= s1_frame_q;
      fwd_data_q <= {winner, age_new};
    end
  end

  // Control state, valid bits, run registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      has_q        <= '0;
      rd_has_q     <= 1'b0;
      fwd_valid_q  <= 1'b0;
      best_q       <= '0;
      first_q      <= '0;
      lastb_q      <= '0;
      tied_q       <= 1'b0;
      cib_q        <= 1'b0;
      cseen_q      <= 1'b0;
      cscore_q     <= '0;
      started_q    <= 1'b0;
      tie_mode_q   <= TIE_FIRST;
      min_commit_q <= '0;
      margin_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_acc) begin
        rd_has_q <= has_q[in_frame];
      end
      if (s1_fire) begin
        has_q[s1_frame_q] <= 1'b1;
        fwd_valid_q       <= 1'b1;
      end
      if (s1_valid_q && s1_adv) begin
        if (s1_last_q) begin
          best_q    <= '0;
          first_q   <= '0;
          lastb_q   <= '0;
          tied_q    <= 1'b0;
          cib_q     <= 1'b0;
          cseen_q   <= 1'b0;
          cscore_q  <= '0;
          started_q <= 1'b0;
        end else begin
          best_q    <= best_d;
          first_q   <= first_d;
          lastb_q   <= lastb_d;
          tied_q    <= tied_d;
          cib_q     <= cib_d;
          cseen_q   <= cseen_d;
          cscore_q  <= cscore_d;
          started_q <= 1'b1;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TIE_BREAK:  tie_mode_q   <= cfg_data_i[1:0];
          REG_MIN_COMMIT: min_commit_q <= cfg_data_i;
          REG_HYSTERESIS: margin_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      chosen_target_o      <= winner;
      resume_pc_out_o      <= s1_pc_q;
      tie_break_used_o     <= tied_d;
      min_commit_blocked_o <= min_blk;
      hysteresis_blocked_o <= hys_blk;
      had_commit_before_o  <= has_c;
      commit_before_o      <= has_c ? ctgt_c : '0;
      if (!has_c) begin
        age_before_o <= '0;
      end else if (age_ext > AGE_EXT'(16'hFFFF)) begin
        age_before_o <= 16'hFFFF;
      end else begin
        age_before_o <= age_ext[15:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/ucwh_checker.sv]
module ucwh_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [ucwh_pkg::TARGET_W-1:0]        chosen_target_o,
  input logic [ucwh_pkg::PC_W-1:0]            resume_pc_out_o,
  input logic                                 min_commit_blocked_o,
  input logic                                 hysteresis_blocked_o,
  input logic                                 had_commit_before_o,
  input logic [ucwh_pkg::TARGET_W-1:0]        commit_before_o,
  input logic [15:0]                          age_before_o
);

  // A stalled result stays offered with the same target and program counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chosen_target_o)
      && $stable(resume_pc_out_o))
    else $error("stalled result changed");

  // Only one of the two guards can hold a decision back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(min_commit_blocked_o && hysteresis_blocked_o))
    else $error("both guards reported");

  // A blocked switch keeps the target that was committed before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (min_commit_blocked_o || hysteresis_blocked_o)
      |-> had_commit_before_o && (chosen_target_o == commit_before_o))
    else $error("blocked switch did not keep the committed target");

  // Without a prior commitment the before fields read zero and nothing blocks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !had_commit_before_o
      |-> (commit_before_o == '0) && (age_before_o == '0)
        && !min_commit_blocked_o && !hysteresis_blocked_o)
    else $error("fields set without a prior commitment");

endmodule

bind utility_choice_with_hysteresis_core ucwh_checker u_ucwh_checker (.*);
